// ===== hw/rtl/rom_ram_bank_controller_core_macros.svh =====
// Assertion helpers used by the RTL back end.
`ifndef ROM_RAM_BANK_CONTROLLER_CORE_MACROS_SVH
`define ROM_RAM_BANK_CONTROLLER_CORE_MACROS_SVH

// Same-cycle implication under the asynchronous reset.
`define RRBC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rrbc assertion failed");

// Next-cycle implication under the asynchronous reset.
`define RRBC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rrbc assertion failed");

`endif

// ===== hw/rtl/rrbc_pkg.sv =====
package rrbc_pkg;

	localparam int ROM_W     = 21;
	localparam int RAM_IDX_W = 15;
	localparam int CMD_DEPTH = 2;
	localparam int RES_DEPTH = 4;

	localparam logic [2:0] KIND_ROM_READ  = 3'd0;
	localparam logic [2:0] KIND_RAM       = 3'd1;
	localparam logic [2:0] KIND_RAM_OFF   = 3'd2;
	localparam logic [2:0] KIND_REG_WRITE = 3'd3;
	localparam logic [2:0] KIND_UNMAPPED  = 3'd4;

	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	// Configuration register index (paddr[2])
	localparam logic REG_ROM_MASK = 1'b0;
	localparam logic REG_RAM_MASK = 1'b1;

	// Control register select, address bits 14:13 of a write below 0x8000
	localparam logic [1:0] CTL_RAM_ENABLE = 2'd0;
	localparam logic [1:0] CTL_ROM_BANK   = 2'd1;
	localparam logic [1:0] CTL_UPPER_BITS = 2'd2;
	localparam logic [1:0] CTL_MODE       = 2'd3;

	localparam logic [7:0] BYTE_OPEN = 8'hFF;

	typedef struct packed {
		logic       operation;
		logic [15:0] address;
		logic [7:0]  write_data;
	} access_t;

	typedef struct packed {
		logic [7:0]       read_data;
		logic [ROM_W-1:0] rom_address;
		logic [2:0]       access_kind;
	} result_t;

	typedef struct packed {
		logic [ROM_W-1:0]     rom_mask;
		logic [RAM_IDX_W-1:0] ram_mask;
	} cfg_t;

	// Classified transaction handed from front to back
	typedef struct packed {
		logic [2:0]           kind;
		logic [ROM_W-1:0]     rom_address;
		logic [7:0]           read_data;
		logic                 ram_rd;
		logic                 ram_wr;
		logic [RAM_IDX_W-1:0] ram_index;
		logic [7:0]           write_data;
	} cmd_t;

endpackage

// ===== hw/rtl/rom_ram_bank_controller_core.sv =====
// Path: accepted transactions go from the command queue to s1, then to the result queue.
// Throughput: one transaction per cycle sustained on both sides while the receiver pops; the
// cart RAM has one read/write port, used at most once per cycle by the back end.
// Reset (arst_n low): bank registers and queues clear, masks return to 0x7FFF and 0x1FFF.
// Cart RAM contents are not cleared and are undefined until written.
module rom_ram_bank_controller_core import rrbc_pkg::*; #(
	parameter int RAM_BYTES     = 32768,
	parameter int ROM_ADDR_BITS = 21
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  access_t     access,
	output logic        empty,
	input  logic        pop,
	output result_t     result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	cfg_t cfg_q;
	logic cfg_wr;
	logic cmd_valid;
	cmd_t cmd_in;
	cmd_t cmd_out;
	logic cmd_full;
	logic cmd_empty;
	logic cmd_pop;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rom_mask <= ROM_W'(21'h007FFF);
			cfg_q.ram_mask <= RAM_IDX_W'(15'h1FFF);
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_ROM_MASK: cfg_q.rom_mask <= pwdata[ROM_W-1:0];
				REG_RAM_MASK: cfg_q.ram_mask <= pwdata[RAM_IDX_W-1:0];
				default:      cfg_q          <= cfg_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_ROM_MASK: prdata = 32'(cfg_q.rom_mask);
			REG_RAM_MASK: prdata = 32'(cfg_q.ram_mask);
			default:      prdata = '0;
		endcase
	end

	assign full = cmd_full;

	rrbc_front #(
		.ROM_ADDR_BITS (ROM_ADDR_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.access    (access),
		.cfg       (cfg_q),
		.cmd_full  (cmd_full),
		.cmd_valid (cmd_valid),
		.cmd       (cmd_in)
	);

	rrbc_fifo #(
		.W     ($bits(cmd_t)),
		.DEPTH (CMD_DEPTH)
	) u_cmd_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd_valid),
		.wr_data (cmd_in),
		.full    (cmd_full),
		.rd_en   (cmd_pop),
		.rd_data (cmd_out),
		.empty   (cmd_empty),
		.count   ()
	);

	rrbc_back #(
		.RAM_BYTES (RAM_BYTES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_empty (cmd_empty),
		.cmd       (cmd_out),
		.cmd_pop   (cmd_pop),
		.pop       (pop),
		.empty     (empty),
		.result    (result)
	);

endmodule

// ===== hw/rtl/rrbc_fifo.sv =====
module rrbc_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 2
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  logic [W-1:0]               wr_data,
	output logic                       full,
	input  logic                       rd_en,
	output logic [W-1:0]               rd_data,
	output logic                       empty,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign count   = count_q;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== hw/rtl/rrbc_front.sv =====
module rrbc_front import rrbc_pkg::*; #(
	parameter int ROM_ADDR_BITS = 21
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  access_t access,
	input  cfg_t    cfg,
	input  logic    cmd_full,
	output logic    cmd_valid,
	output cmd_t    cmd
);

	localparam logic [ROM_W-1:0] ROM_LIM = ROM_W'((64'd1 << ROM_ADDR_BITS) - 64'd1);

	logic       ram_enabled_q;
	logic [4:0] lower_bank_q;
	logic [1:0] upper_bits_q;
	logic       banking_mode_q;

	logic             accept;
	logic             is_wr;
	logic             in_ctrl;
	logic             in_ram;
	logic [4:0]       bank;
	logic [1:0]       upper_eff;
	logic [ROM_W-1:0] rom_raw;
	logic [RAM_IDX_W-1:0] ram_raw;

	assign accept = push && !cmd_full;
	assign is_wr  = (access.operation == OP_WRITE);
	assign in_ctrl = !access.address[15];
	assign in_ram  = (access.address[15:13] == 3'b101);

	// Bank zero maps to bank one in the switchable window
	assign bank      = (lower_bank_q == 5'd0) ? 5'd1 : lower_bank_q;
	assign upper_eff = banking_mode_q ? upper_bits_q : 2'b00;

	always_comb begin
		if (!access.address[14]) begin
			rom_raw = {upper_eff, 5'd0, access.address[13:0]};
		end else begin
			rom_raw = {upper_bits_q, bank, access.address[13:0]};
		end
		ram_raw = {upper_eff, access.address[12:0]};
	end

	always_comb begin
		cmd             = '0;
		cmd.write_data  = access.write_data;
		cmd.ram_index   = ram_raw & cfg.ram_mask;
		if (in_ctrl) begin
			if (is_wr) begin
				cmd.kind = KIND_REG_WRITE;
			end else begin
				cmd.kind        = KIND_ROM_READ;
				cmd.rom_address = rom_raw & cfg.rom_mask & ROM_LIM;
			end
		end else if (in_ram) begin
			if (ram_enabled_q) begin
				cmd.kind   = KIND_RAM;
				cmd.ram_wr = is_wr;
				cmd.ram_rd = !is_wr;
			end else begin
				cmd.kind      = KIND_RAM_OFF;
				cmd.read_data = is_wr ? 8'h00 : BYTE_OPEN;
			end
		end else begin
			cmd.kind      = KIND_UNMAPPED;
			cmd.read_data = is_wr ? 8'h00 : BYTE_OPEN;
		end
	end

	assign cmd_valid = accept;

	// Bank registers change in transaction order, ahead of the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ram_enabled_q  <= 1'b0;
			lower_bank_q   <= 5'd0;
			upper_bits_q   <= 2'd0;
			banking_mode_q <= 1'b0;
		end else if (accept && in_ctrl && is_wr) begin
			case (access.address[14:13])
				CTL_RAM_ENABLE: ram_enabled_q  <= (access.write_data[3:0] & 4'hA) == 4'hA;
				CTL_ROM_BANK:   lower_bank_q   <= access.write_data[4:0];
				CTL_UPPER_BITS: upper_bits_q   <= access.write_data[1:0];
				default:        banking_mode_q <= access.write_data[0];
			endcase
		end
	end

endmodule

// ===== hw/rtl/rrbc_back.sv =====
`include "rom_ram_bank_controller_core_macros.svh"

module rrbc_back import rrbc_pkg::*; #(
	parameter int RAM_BYTES = 32768
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    cmd_empty,
	input  cmd_t    cmd,
	output logic    cmd_pop,
	input  logic    pop,
	output logic    empty,
	output result_t result
);

	localparam int IW = $clog2(RAM_BYTES);
	localparam int CW = $clog2(RES_DEPTH + 1);

	logic [7:0] mem [RAM_BYTES];

	logic             valid_s1;
	logic [2:0]       kind_s1;
	logic [ROM_W-1:0] rom_s1;
	logic [7:0]       rd_s1;
	logic             ram_rd_s1;
	logic [7:0]       rdata_s1;

	logic          issue;
	logic [IW-1:0] idx;
	logic          out_full;
	logic [CW-1:0] out_count;
	logic          out_pop;
	result_t       res_s1;

	// Issue only with room reserved for the transaction already in flight
	assign issue = !cmd_empty
		&& ((CW + 1)'(out_count) + (CW + 1)'(valid_s1) < (CW + 1)'(RES_DEPTH));
	assign cmd_pop = issue;
	assign idx     = cmd.ram_index[IW-1:0];

	always_ff @(posedge clk) begin
		if (issue) begin
			if (cmd.ram_wr) begin
				mem[idx] <= cmd.write_data;
			end
			rdata_s1 <= mem[idx];
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			kind_s1   <= cmd.kind;
			rom_s1    <= cmd.rom_address;
			rd_s1     <= cmd.read_data;
			ram_rd_s1 <= cmd.ram_rd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= issue;
		end
	end

	always_comb begin
		res_s1.read_data   = ram_rd_s1 ? rdata_s1 : rd_s1;
		res_s1.rom_address = rom_s1;
		res_s1.access_kind = kind_s1;
	end

	assign out_pop = pop && !empty;

	rrbc_fifo #(
		.W     ($bits(result_t)),
		.DEPTH (RES_DEPTH)
	) u_res_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (valid_s1),
		.wr_data (res_s1),
		.full    (out_full),
		.rd_en   (out_pop),
		.rd_data (result),
		.empty   (empty),
		.count   (out_count)
	);

	`RRBC_ASSERT_NOW(a_s1_has_room, clk, arst_n, valid_s1, !out_full)
	`RRBC_ASSERT_NEXT(a_full_blocks_issue, clk, arst_n, out_full, !valid_s1)
	`RRBC_ASSERT_NOW(a_ram_cmd_kind, clk, arst_n, issue && (cmd.ram_wr || cmd.ram_rd), cmd.kind == KIND_RAM)
	`RRBC_ASSERT_NOW(a_ram_read_kind, clk, arst_n, valid_s1 && ram_rd_s1, kind_s1 == KIND_RAM)

endmodule

// ===== tb/sv/rom_ram_bank_controller_core_tb.sv =====
`timescale 1ns / 1ps

module rom_ram_bank_controller_core_tb;
	import rrbc_pkg::*;

	typedef struct {
		access_t acc;
		bit      typed;
		result_t res;
	} bus_row_t;

	localparam int PHASE_ITEMS = 160;
	localparam int N_SETTINGS  = 5;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	access_t     access = '0;
	logic        empty;
	logic        pop = 1'b0;
	result_t     result;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	// bank controller state as the testbench sees it
	logic [ROM_W-1:0]     rom_size_mask;
	logic [RAM_IDX_W-1:0] ram_size_mask;
	bit                   ram_on;
	logic [4:0]           low_bank;
	logic [1:0]           up_bits;
	bit                   mode1;
	logic [7:0]           ram_image [32768];
	bit                   ram_written [32768];

	result_t     expected_q [$];
	bus_row_t    bus_rows [$];
	logic [15:0] ram_recent [$];

	int  errors = 0;
	int  kind_seen [5];
	int  full_cycles = 0;
	int  stage = 0;
	bit  calm_tx = 1'b0;
	bit  hold_rx = 1'b0;
	bit  rx_calm = 1'b0;
	int  rx_wait = 0;
	int  rx_tick = 0;

	rom_ram_bank_controller_core DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.access  (access),
		.empty   (empty),
		.pop     (pop),
		.result  (result),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #5 clk = ~clk;

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(0, 2);
		else if (r < 95)
			return $urandom_range(3, 8);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [ROM_W-1:0] rom_map(input logic [15:0] addr);
		logic [4:0]       bank;
		logic [ROM_W-1:0] a;
		bank = (low_bank == 5'd0) ? 5'd1 : low_bank;
		if (!addr[14])
			a = {mode1 ? up_bits : 2'b00, 5'd0, addr[13:0]};
		else
			a = {up_bits, bank, addr[13:0]};
		return a & rom_size_mask;
	endfunction

	function automatic logic [RAM_IDX_W-1:0] ram_slot(input logic [15:0] addr);
		return {mode1 ? up_bits : 2'b00, addr[12:0]} & ram_size_mask;
	endfunction

	function automatic void bank_step(input access_t a, output result_t r);
		logic [RAM_IDX_W-1:0] slot;
		r = '0;
		if (!a.address[15]) begin
			if (a.operation == OP_WRITE) begin
				case (a.address[14:13])
					CTL_RAM_ENABLE: ram_on = (a.write_data & 8'h0A) == 8'h0A;
					CTL_ROM_BANK:   low_bank = a.write_data[4:0];
					CTL_UPPER_BITS: up_bits = a.write_data[1:0];
					default:        mode1 = a.write_data[0];
				endcase
				r.access_kind = KIND_REG_WRITE;
			end else begin
				r.rom_address = rom_map(a.address);
				r.access_kind = KIND_ROM_READ;
			end
		end else if (a.address[15:13] == 3'b101) begin
			if (!ram_on) begin
				r.access_kind = KIND_RAM_OFF;
				if (a.operation == OP_READ)
					r.read_data = BYTE_OPEN;
			end else begin
				slot = ram_slot(a.address);
				r.access_kind = KIND_RAM;
				if (a.operation == OP_WRITE) begin
					ram_image[slot] = a.write_data;
					ram_written[slot] = 1'b1;
				end else begin
					r.read_data = ram_image[slot];
				end
			end
		end else begin
			r.access_kind = KIND_UNMAPPED;
			if (a.operation == OP_READ)
				r.read_data = BYTE_OPEN;
		end
	endfunction

	function automatic void check_field(input string what, input longint want,
			input longint got);
		if (want != got) begin
			errors++;
			$display("%0t: %s mismatch, expected 0x%0h got 0x%0h", $time, what, want, got);
		end
	endfunction

	function automatic void add_row(input logic op, input logic [15:0] addr,
			input logic [7:0] data, input bit typed, input logic [7:0] rd,
			input logic [ROM_W-1:0] rom, input logic [2:0] kind);
		bus_row_t row;
		row.acc = '{operation: op, address: addr, write_data: data};
		row.typed = typed;
		row.res = '{read_data: rd, rom_address: rom, access_kind: kind};
		bus_rows.push_back(row);
	endfunction

	// Build one random bus access, weighted toward well-formed RAM traffic.
	function automatic access_t make_access();
		access_t     a;
		logic [15:0] pick;
		int          r;
		int          k;
		r = $urandom_range(0, 99);
		a.write_data = 8'($urandom);
		a.operation = OP_WRITE;
		if (r < 8) begin
			a.address = {1'b0, CTL_RAM_ENABLE, 13'($urandom)};
			if ($urandom_range(0, 4) != 0)
				a.write_data = a.write_data | 8'h0A;
		end else if (r < 14) begin
			a.address = {1'b0, CTL_ROM_BANK, 13'($urandom)};
		end else if (r < 20) begin
			a.address = {1'b0, CTL_UPPER_BITS, 13'($urandom)};
		end else if (r < 25) begin
			a.address = {1'b0, CTL_MODE, 13'($urandom)};
		end else if (r < 45) begin
			a.operation = OP_READ;
			a.address = {1'b0, 15'($urandom)};
		end else if (r < 68) begin
			a.address = {3'b101, 13'($urandom)};
		end else if (r < 90) begin
			// read back only what was written; fall back to a write
			a.address = {3'b101, 13'($urandom)};
			for (k = 0; k < 8; k++) begin
				if (ram_recent.size() != 0 && k[0] == 1'b0)
					pick = ram_recent[$urandom_range(0, ram_recent.size() - 1)];
				else
					pick = {3'b101, 13'($urandom)};
				if (!ram_on || ram_written[ram_slot(pick)]) begin
					a.operation = OP_READ;
					a.address = pick;
					break;
				end
			end
		end else begin
			a.operation = $urandom_range(0, 1) ? OP_WRITE : OP_READ;
			if ($urandom_range(0, 1))
				a.address = {3'b100, 13'($urandom)};
			else
				a.address = {2'b11, 14'($urandom)};
		end
		if (a.operation == OP_WRITE && a.address[15:13] == 3'b101) begin
			ram_recent.push_back(a.address);
			if (ram_recent.size() > 64)
				void'(ram_recent.pop_front());
		end
		return a;
	endfunction

	task automatic send_access(input access_t a, input bit typed, input result_t want);
		result_t pred;
		int      gap;
		push <= 1'b1;
		access <= a;
		@(posedge clk);
		while (full) begin
			full_cycles++;
			@(posedge clk);
		end
		bank_step(a, pred);
		expected_q.push_back(typed ? want : pred);
		gap = (calm_tx || $urandom_range(0, 2) != 0) ? 0 : idle_len();
		if (gap != 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic apb_cycle(input bit wr, input logic idx, input logic [31:0] wdata,
			output logic [31:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_masks(input logic [ROM_W-1:0] rom_m, input logic [RAM_IDX_W-1:0] ram_m);
		logic [31:0] rd;
		apb_cycle(1'b1, REG_ROM_MASK, 32'(rom_m), rd);
		apb_cycle(1'b1, REG_RAM_MASK, 32'(ram_m), rd);
		rom_size_mask = rom_m;
		ram_size_mask = ram_m;
		apb_cycle(1'b0, REG_ROM_MASK, '0, rd);
		check_field("rom mask readback", rom_m, rd[ROM_W-1:0]);
		apb_cycle(1'b0, REG_RAM_MASK, '0, rd);
		check_field("ram mask readback", ram_m, rd[RAM_IDX_W-1:0]);
	endtask

	task automatic drain();
		push <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Result side: check each transaction, then decide next pop.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && pop && !empty) begin
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none got %h", $time, result);
			end else begin
				want = expected_q.pop_front();
				check_field("read_data", want.read_data, result.read_data);
				check_field("rom_address", want.rom_address, result.rom_address);
				check_field("access_kind", want.access_kind, result.access_kind);
				if (result.access_kind <= KIND_UNMAPPED)
					kind_seen[result.access_kind]++;
			end
		end
		rx_tick <= (rx_tick == 299) ? 0 : rx_tick + 1;
		if (rx_tick == 299)
			rx_calm <= ($urandom_range(0, 2) == 0);
		if (hold_rx || rx_wait != 0) begin
			pop <= 1'b0;
			if (rx_wait != 0)
				rx_wait <= rx_wait - 1;
		end else if (!rx_calm && $urandom_range(0, 3) == 0) begin
			pop <= 1'b0;
			rx_wait <= idle_len();
		end else begin
			pop <= 1'b1;
		end
	end

	// Long receiver hold-off so the block fills and backs up the input.
	initial begin
		int n;
		wait (stage == 2);
		@(posedge clk);
		n = $urandom_range(150, 250);
		hold_rx <= 1'b1;
		repeat (n) @(posedge clk);
		hold_rx <= 1'b0;
	end

	initial begin
		#5_000_000;
		$display("FAIL rom_ram_bank_controller_core");
		$finish;
	end

	initial begin
		logic [ROM_W-1:0]     rom_set [N_SETTINGS];
		logic [RAM_IDX_W-1:0] ram_set [N_SETTINGS];
		bus_row_t             row;
		int                   p;
		int                   i;

		rom_size_mask = 21'h007FFF;
		ram_size_mask = 15'h1FFF;
		ram_on = 1'b0;
		low_bank = '0;
		up_bits = '0;
		mode1 = 1'b0;

		rom_set[0] = 21'h1FFFFF; ram_set[0] = 15'h7FFF;
		rom_set[1] = 21'h007FFF; ram_set[1] = 15'h0000;
		rom_set[2] = 21'h0FFFFF; ram_set[2] = 15'h07FF;
		rom_set[3] = 21'h15A5A5; ram_set[3] = 15'h2AAA;
		rom_set[4] = 21'((1 << $urandom_range(15, 21)) - 1);
		ram_set[4] = 15'((1 << $urandom_range(11, 15)) - 1);

		// after reset: RAM off, bank 0 mapped as 1, masks at reset values
		add_row(OP_READ,  16'h0000, 8'h00, 1, 8'h00, 21'h000000, KIND_ROM_READ);
		add_row(OP_READ,  16'h3FFF, 8'hFF, 1, 8'h00, 21'h003FFF, KIND_ROM_READ);
		add_row(OP_READ,  16'h4000, 8'h00, 1, 8'h00, 21'h004000, KIND_ROM_READ);
		add_row(OP_READ,  16'h7FFF, 8'h00, 1, 8'h00, 21'h007FFF, KIND_ROM_READ);
		add_row(OP_READ,  16'hA000, 8'h00, 1, BYTE_OPEN, '0, KIND_RAM_OFF);
		add_row(OP_WRITE, 16'hA000, 8'h55, 1, 8'h00, '0, KIND_RAM_OFF);
		add_row(OP_READ,  16'h8000, 8'h00, 1, BYTE_OPEN, '0, KIND_UNMAPPED);
		add_row(OP_WRITE, 16'h9FFF, 8'hAA, 1, 8'h00, '0, KIND_UNMAPPED);
		add_row(OP_READ,  16'hC000, 8'h00, 1, BYTE_OPEN, '0, KIND_UNMAPPED);
		add_row(OP_READ,  16'hFFFF, 8'h00, 1, BYTE_OPEN, '0, KIND_UNMAPPED);
		add_row(OP_WRITE, 16'hFFFF, 8'hFF, 1, 8'h00, '0, KIND_UNMAPPED);
		add_row(OP_WRITE, 16'h0000, 8'h0A, 1, 8'h00, '0, KIND_REG_WRITE);
		add_row(OP_WRITE, 16'hA000, 8'h5A, 1, 8'h00, '0, KIND_RAM);
		add_row(OP_READ,  16'hA000, 8'h00, 1, 8'h5A, '0, KIND_RAM);
		add_row(OP_WRITE, 16'hBFFF, 8'hFF, 1, 8'h00, '0, KIND_RAM);
		add_row(OP_WRITE, 16'h2000, 8'h00, 1, 8'h00, '0, KIND_REG_WRITE);
		add_row(OP_READ,  16'h4123, 8'h00, 0, '0, '0, '0);
		add_row(OP_WRITE, 16'h3FFF, 8'hFF, 1, 8'h00, '0, KIND_REG_WRITE);
		add_row(OP_WRITE, 16'h4000, 8'hFF, 1, 8'h00, '0, KIND_REG_WRITE);
		add_row(OP_READ,  16'h7FFF, 8'h00, 0, '0, '0, '0);
		add_row(OP_WRITE, 16'h6000, 8'h01, 1, 8'h00, '0, KIND_REG_WRITE);
		add_row(OP_READ,  16'h0123, 8'h00, 0, '0, '0, '0);
		add_row(OP_READ,  16'hBFFF, 8'h00, 0, '0, '0, '0);
		add_row(OP_WRITE, 16'h7FFF, 8'hFE, 1, 8'h00, '0, KIND_REG_WRITE);
		add_row(OP_WRITE, 16'h1FFF, 8'h0B, 1, 8'h00, '0, KIND_REG_WRITE);
		add_row(OP_WRITE, 16'h0000, 8'h00, 1, 8'h00, '0, KIND_REG_WRITE);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (bus_rows[i]) begin
			row = bus_rows[i];
			send_access(row.acc, row.typed, row.res);
		end
		drain();

		for (p = 0; p < N_SETTINGS; p++) begin
			set_masks(rom_set[p], ram_set[p]);
			calm_tx = (p == 1);
			stage = p + 1;
			for (i = 0; i < PHASE_ITEMS; i++)
				send_access(make_access(), 1'b0, '0);
			drain();
		end

		$display("Covered %0d checked transactions: rom %0d, ram %0d, ram off %0d,",
			kind_seen[KIND_ROM_READ] + kind_seen[KIND_RAM] + kind_seen[KIND_RAM_OFF]
			+ kind_seen[KIND_REG_WRITE] + kind_seen[KIND_UNMAPPED],
			kind_seen[KIND_ROM_READ], kind_seen[KIND_RAM], kind_seen[KIND_RAM_OFF]);
		$display("reg %0d, unmapped %0d over %0d mask settings; input held off on %0d cycles",
			kind_seen[KIND_REG_WRITE], kind_seen[KIND_UNMAPPED], N_SETTINGS, full_cycles);
		if (errors == 0)
			$display("PASS rom_ram_bank_controller_core");
		else
			$display("FAIL rom_ram_bank_controller_core");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/rrbc_pkg.sv
hw/rtl/rrbc_fifo.sv
hw/rtl/rrbc_front.sv
hw/rtl/rrbc_back.sv
hw/rtl/rom_ram_bank_controller_core.sv
tb/sv/rom_ram_bank_controller_core_tb.sv
